/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; define ASSERT_OFF to drop them all.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

/* rtl/tmg_pkg.sv */
// ----------------------------------------------------------------------------
// tmg_pkg
// Types and constants of the torus mesh generator.
// ----------------------------------------------------------------------------
package tmg_pkg;

  typedef enum logic {
    OpVertex = 1'b0,
    OpCell   = 1'b1
  } opcode_e;

  typedef enum logic [3:0] {
    CfgRingRadius  = 4'd0,
    CfgTubeRadius  = 4'd1,
    CfgRingSegs    = 4'd2,
    CfgTubeSegs    = 4'd3,
    CfgTexLeft     = 4'd4,
    CfgTexTop      = 4'd5,
    CfgTexWidth    = 4'd6,
    CfgTexHeight   = 4'd7
  } cfg_reg_e;

  // Fields that ride along the pipeline next to the arithmetic.
  typedef struct packed {
    logic        is_cell;
    logic        last;
    logic [15:0] corner_a;
    logic [15:0] corner_b;
    logic [15:0] corner_c;
  } side_t;

  // pi/2 in unsigned Q2.30.
  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;

  // Quotient bits of the pipelined dividers.
  localparam int unsigned QuoW = 16;

endpackage

/* rtl/tmg_divider.sv */
// ----------------------------------------------------------------------------
// tmg_divider
// Pipelined restoring divider, one quotient bit per stage, with an overflow
// flag for quotients that do not fit.
// ----------------------------------------------------------------------------
module tmg_divider #(
  parameter int unsigned NumW = 20,
  parameter int unsigned DenW = 8
) (
  input  logic                       clk_i,
  input  logic [NumW-1:0]            num_i,
  input  logic [DenW-1:0]            den_i,
  output logic [tmg_pkg::QuoW-1:0]   quo_o,
  output logic                       ovf_o
);

  localparam int unsigned QW   = tmg_pkg::QuoW;
  localparam int unsigned CmpW = (NumW > DenW + QW) ? NumW : DenW + QW;

  logic [NumW-1:0] rem_q [QW+1];
  logic [DenW-1:0] den_q [QW+1];
  logic [QW-1:0]   quo_q [QW+1];
  logic            ovf_q [QW+1];

  // First stage only checks whether the quotient fits.
  always_ff @(posedge clk_i) begin
    rem_q[0] <= num_i;
    den_q[0] <= den_i;
    quo_q[0] <= '0;
    ovf_q[0] <= CmpW'(num_i) >= (CmpW'(den_i) << QW);
  end

  for (genvar s = 1; s <= QW; s++) begin : g_step
    localparam int unsigned Bit = QW - s;
    logic [CmpW-1:0] rem_ext;
    logic [CmpW-1:0] den_sh;
    logic            take;

    assign rem_ext = CmpW'(rem_q[s-1]);
    assign den_sh  = CmpW'(den_q[s-1]) << Bit;
    assign take    = rem_ext >= den_sh;

    always_ff @(posedge clk_i) begin
      rem_q[s] <= take ? NumW'(rem_ext - den_sh) : rem_q[s-1];
      den_q[s] <= den_q[s-1];
      ovf_q[s] <= ovf_q[s-1];
      quo_q[s] <= quo_q[s-1] | (QW'(take) << Bit);
    end
  end

  assign quo_o = quo_q[QW];
  assign ovf_o = ovf_q[QW];

endmodule

/* rtl/torus_mesh_generator.sv */
// ----------------------------------------------------------------------------
// torus_mesh_generator
// Throughput: one vertex item per cycle while busy is low; a cell item
// holds off the next item, since its two triangles leave one per cycle
// (busy is high for the second).
// The receiver cannot stall, so nothing downstream ever holds the pipeline.
// Reset clears the pipeline valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
module torus_mesh_generator #(
  parameter int unsigned SINE_TABLE_DEPTH = 1024,
  parameter int unsigned TEX_IMAGE_W      = 512,
  parameter int unsigned TEX_IMAGE_H      = 512
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Item channel.
  input  logic               start,
  output logic               busy,
  input  logic               opcode_i,
  input  logic [7:0]         ring_step_i,
  input  logic [7:0]         tube_step_i,
  // Register write channel.
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [3:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  // Results.
  output logic               done_o,
  output logic signed [17:0] pos_x_o,
  output logic signed [17:0] pos_y_o,
  output logic signed [17:0] pos_z_o,
  output logic signed [16:0] norm_x_o,
  output logic signed [16:0] norm_y_o,
  output logic signed [16:0] norm_z_o,
  output logic [15:0]        tex_u_o,
  output logic [15:0]        tex_v_o,
  output logic [15:0]        corner_a_o,
  output logic [15:0]        corner_b_o,
  output logic [15:0]        corner_c_o,
  output logic               last_o
);

  // The pipeline never stalls, because results cannot be held off. Stages:
  //   acc   accepted item with clamped grid indices
  //   b     phase and texture dividends, triangle corner indices
  //   div   17 stages of restoring division (overflow check + 16 bits)
  //   dec   quadrant decode of the four phases, texture saturation
  //   rom   quarter-wave table reads
  //   sgn   signed sine and cosine values
  //   mul1  tube*cos(v), tube*sin(v), ring*cos(u), ring*sin(u)
  //   mul2  (tube*cos v)*cos u and (tube*cos v)*sin u
  //   out   result register with its strobe
  // A cell item enters twice, once per triangle; the second pass is
  // injected from the acc stage in the following cycle.

  localparam int unsigned Quarter  = SINE_TABLE_DEPTH / 4;
  localparam int unsigned FullTurn = 4 * Quarter;
  localparam int unsigned AddrW    = $clog2(Quarter + 1);
  localparam int unsigned PhW      = $clog2(5 * Quarter + 1);
  localparam int unsigned PhNumW   = $clog2(255 * FullTurn + 1);
  localparam int unsigned TexDenUW = $clog2(255 * TEX_IMAGE_W + 1);
  localparam int unsigned TexDenVW = $clog2(255 * TEX_IMAGE_H + 1);
  // (base*n + span*k) stays below 2^21; shifted by 16 and with half the
  // divisor added the dividend stays below 2^38.
  localparam int unsigned TexNumW  = 38;
  localparam int unsigned QW       = tmg_pkg::QuoW;
  localparam int unsigned DivLat   = QW + 1;

  // --------------------------------------------------------------------------
  // Quarter-wave sine table, Q1.16, built at elaboration from a Taylor series
  // in Q2.30.
  // --------------------------------------------------------------------------
  typedef logic [16:0] rom_t [Quarter+1];

  function automatic logic [16:0] quarter_sine(input int unsigned r);
    logic [63:0]        x;
    logic [63:0]        term;
    logic signed [63:0] sum;
    x    = 64'(r) * tmg_pkg::HalfPiQ30 / Quarter;
    term = x;
    sum  = $signed(x);
    term = (term * x) >> 30;
    term = ((term * x) >> 30) / 64'd6;
    sum  = sum - $signed(term);
    term = (term * x) >> 30;
    term = ((term * x) >> 30) / 64'd20;
    sum  = sum + $signed(term);
    term = (term * x) >> 30;
    term = ((term * x) >> 30) / 64'd42;
    sum  = sum - $signed(term);
    term = (term * x) >> 30;
    term = ((term * x) >> 30) / 64'd72;
    sum  = sum + $signed(term);
    term = (term * x) >> 30;
    term = ((term * x) >> 30) / 64'd110;
    sum  = sum - $signed(term);
    term = (term * x) >> 30;
    term = ((term * x) >> 30) / 64'd156;
    sum  = sum + $signed(term);
    term = (term * x) >> 30;
    term = ((term * x) >> 30) / 64'd210;
    sum  = sum - $signed(term);
    if (sum < 0) begin
      sum = 0;
    end
    sum = (sum + 64'sd8192) >>> 14;
    if (sum > 64'sd65536) begin
      sum = 64'sd65536;
    end
    return sum[16:0];
  endfunction

  function automatic rom_t build_rom();
    rom_t t;
    for (int unsigned r = 0; r <= Quarter; r++) begin
      t[r] = quarter_sine(r);
    end
    return t;
  endfunction

  // Two copies, one per angle, so each is read at two addresses a cycle.
  localparam rom_t RingRom = build_rom();
  localparam rom_t TubeRom = build_rom();

  // Splits a phase (up to five quarters) into a table address and a sign.
  function automatic logic [AddrW:0] decode_phase(input logic [PhW-1:0] p);
    logic [2:0]     m;
    logic [PhW-1:0] base;
    logic [PhW-1:0] r;
    logic [AddrW-1:0] addr;
    m = '0;
    for (int unsigned k = 1; k <= 5; k++) begin
      if (p >= PhW'(k * Quarter)) begin
        m = m + 3'd1;
      end
    end
    case (m)
      3'd0:    base = '0;
      3'd1:    base = PhW'(Quarter);
      3'd2:    base = PhW'(2 * Quarter);
      3'd3:    base = PhW'(3 * Quarter);
      3'd4:    base = PhW'(4 * Quarter);
      default: base = PhW'(5 * Quarter);
    endcase
    r = p - base;
    if (m[0]) begin
      addr = AddrW'(Quarter) - AddrW'(r);
    end else begin
      addr = AddrW'(r);
    end
    return {m[1], addr};
  endfunction

  // --------------------------------------------------------------------------
  // Config regs. Writes must arrive only while the block is idle; unchecked.
  // --------------------------------------------------------------------------
  logic [15:0] ring_radius_q, tube_radius_q;
  logic [7:0]  ring_segs_q, tube_segs_q;
  logic [11:0] tex_left_q, tex_top_q, tex_width_q, tex_height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_radius_q <= 16'd256;
      tube_radius_q <= 16'd128;
      ring_segs_q   <= 8'd8;
      tube_segs_q   <= 8'd8;
      tex_left_q    <= '0;
      tex_top_q     <= '0;
      tex_width_q   <= '0;
      tex_height_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (tmg_pkg::cfg_reg_e'(cfg_index_i))
        tmg_pkg::CfgRingRadius: ring_radius_q <= cfg_data_i;
        tmg_pkg::CfgTubeRadius: tube_radius_q <= cfg_data_i;
        tmg_pkg::CfgRingSegs:   ring_segs_q   <= cfg_data_i[7:0];
        tmg_pkg::CfgTubeSegs:   tube_segs_q   <= cfg_data_i[7:0];
        tmg_pkg::CfgTexLeft:    tex_left_q    <= cfg_data_i[11:0];
        tmg_pkg::CfgTexTop:     tex_top_q     <= cfg_data_i[11:0];
        tmg_pkg::CfgTexWidth:   tex_width_q   <= cfg_data_i[11:0];
        tmg_pkg::CfgTexHeight:  tex_height_q  <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  // A segment count of zero behaves as one.
  logic [7:0] n0, n1;
  assign n0 = (ring_segs_q == 8'd0) ? 8'd1 : ring_segs_q;
  assign n1 = (tube_segs_q == 8'd0) ? 8'd1 : tube_segs_q;

  // --------------------------------------------------------------------------
  // Accept stage: index clamping and second-triangle injection.
  // --------------------------------------------------------------------------
  logic       accept;
  logic       pend_q, pend_d;
  logic       acc_valid_q, acc_valid_d;
  logic       acc_cell_q, acc_cell_d;
  logic       acc_tri_q, acc_tri_d;
  logic [7:0] acc_ring_q, acc_ring_d;
  logic [7:0] acc_tube_q, acc_tube_d;
  logic [7:0] ring_lim, tube_lim;

  assign busy   = pend_q;
  assign accept = start && !busy;

  always_comb begin
    // Vertices run to the segment count, cells stop one short of it.
    ring_lim = (opcode_i == tmg_pkg::OpCell) ? n0 - 8'd1 : n0;
    tube_lim = (opcode_i == tmg_pkg::OpCell) ? n1 - 8'd1 : n1;
    pend_d      = accept && (opcode_i == tmg_pkg::OpCell);
    acc_valid_d = accept || pend_q;
    acc_cell_d  = acc_cell_q;
    acc_tri_d   = 1'b0;
    acc_ring_d  = acc_ring_q;
    acc_tube_d  = acc_tube_q;
    if (accept) begin
      acc_cell_d = (opcode_i == tmg_pkg::OpCell);
      acc_ring_d = (ring_step_i > ring_lim) ? ring_lim : ring_step_i;
      acc_tube_d = (tube_step_i > tube_lim) ? tube_lim : tube_step_i;
    end else if (pend_q) begin
      acc_tri_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      acc_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      acc_valid_q <= acc_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_cell_q <= acc_cell_d;
    acc_tri_q  <= acc_tri_d;
    acc_ring_q <= acc_ring_d;
    acc_tube_q <= acc_tube_d;
  end

  // --------------------------------------------------------------------------
  // Dividend stage.
  // --------------------------------------------------------------------------
  logic                b_valid_q;
  tmg_pkg::side_t      b_side_q, b_side_d;
  logic [PhNumW-1:0]   b_ph0_num_q, b_ph1_num_q;
  logic [TexNumW-1:0]  b_u_num_q, b_v_num_q, b_u_num_d, b_v_num_d;
  logic [TexDenUW-1:0] b_u_den_q, b_u_den_d;
  logic [TexDenVW-1:0] b_v_den_q, b_v_den_d;
  logic [20:0]         u_sum, v_sum;
  logic [8:0]          stride;
  logic [15:0]         v00, v01, v10, v11;

  always_comb begin
    // Texture: floor((sum*65536 + den/2) / den) with den = n*image size.
    u_sum     = 21'(tex_left_q) * 21'(n0) + 21'(tex_width_q) * 21'(acc_ring_q);
    v_sum     = 21'(tex_top_q) * 21'(n1) + 21'(tex_height_q) * 21'(acc_tube_q);
    b_u_den_d = TexDenUW'(n0) * TexDenUW'(TEX_IMAGE_W);
    b_v_den_d = TexDenVW'(n1) * TexDenVW'(TEX_IMAGE_H);
    b_u_num_d = TexNumW'({u_sum, 16'h0000}) + TexNumW'(b_u_den_d >> 1);
    b_v_num_d = TexNumW'({v_sum, 16'h0000}) + TexNumW'(b_v_den_d >> 1);

    // Cell corners in the (n0+1) x (n1+1) vertex grid.
    stride = {1'b0, n1} + 9'd1;
    v00    = 16'(acc_ring_q) * 16'(stride) + 16'(acc_tube_q);
    v01    = v00 + 16'd1;
    v10    = v00 + 16'(stride);
    v11    = v10 + 16'd1;

    b_side_d.is_cell = acc_cell_q;
    b_side_d.last    = acc_cell_q ? acc_tri_q : 1'b1;
    if (!acc_cell_q) begin
      b_side_d.corner_a = '0;
      b_side_d.corner_b = '0;
      b_side_d.corner_c = '0;
    end else if (acc_tri_q) begin
      b_side_d.corner_a = v10;
      b_side_d.corner_b = v01;
      b_side_d.corner_c = v11;
    end else begin
      b_side_d.corner_a = v00;
      b_side_d.corner_b = v01;
      b_side_d.corner_c = v10;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= acc_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_side_q    <= b_side_d;
    b_ph0_num_q <= PhNumW'(acc_ring_q) * PhNumW'(FullTurn);
    b_ph1_num_q <= PhNumW'(acc_tube_q) * PhNumW'(FullTurn);
    b_u_num_q   <= b_u_num_d;
    b_v_num_q   <= b_v_num_d;
    b_u_den_q   <= b_u_den_d;
    b_v_den_q   <= b_v_den_d;
  end

  // --------------------------------------------------------------------------
  // Dividers: phase = k*4Q/n and the two texture coordinates.
  // --------------------------------------------------------------------------
  logic [QW-1:0] ph0_quo, ph1_quo, u_quo, v_quo;
  logic          ph0_ovf, ph1_ovf, u_ovf, v_ovf;

  tmg_divider #(.NumW(PhNumW), .DenW(8)) u_div_ph0 (
    .clk_i (clk_i),
    .num_i (b_ph0_num_q),
    .den_i (n0),
    .quo_o (ph0_quo),
    .ovf_o (ph0_ovf)
  );

  tmg_divider #(.NumW(PhNumW), .DenW(8)) u_div_ph1 (
    .clk_i (clk_i),
    .num_i (b_ph1_num_q),
    .den_i (n1),
    .quo_o (ph1_quo),
    .ovf_o (ph1_ovf)
  );

  tmg_divider #(.NumW(TexNumW), .DenW(TexDenUW)) u_div_u (
    .clk_i (clk_i),
    .num_i (b_u_num_q),
    .den_i (b_u_den_q),
    .quo_o (u_quo),
    .ovf_o (u_ovf)
  );

  tmg_divider #(.NumW(TexNumW), .DenW(TexDenVW)) u_div_v (
    .clk_i (clk_i),
    .num_i (b_v_num_q),
    .den_i (b_v_den_q),
    .quo_o (v_quo),
    .ovf_o (v_ovf)
  );

  // Side fields and valid bits run alongside the divider stages.
  logic           dly_valid_q [DivLat];
  tmg_pkg::side_t dly_side_q  [DivLat];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned s = 0; s < DivLat; s++) begin
        dly_valid_q[s] <= 1'b0;
      end
    end else begin
      dly_valid_q[0] <= b_valid_q;
      for (int unsigned s = 1; s < DivLat; s++) begin
        dly_valid_q[s] <= dly_valid_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dly_side_q[0] <= b_side_q;
    for (int unsigned s = 1; s < DivLat; s++) begin
      dly_side_q[s] <= dly_side_q[s-1];
    end
  end

  // --------------------------------------------------------------------------
  // Quadrant decode and texture saturation.
  // --------------------------------------------------------------------------
  logic             dec_valid_q;
  tmg_pkg::side_t   dec_side_q;
  logic [AddrW:0]   dec_c0_q, dec_s0_q, dec_c1_q, dec_s1_q;
  logic [15:0]      dec_u_q, dec_v_q;
  logic [PhW-1:0]   ph0, ph1;

  // The phase dividers never overflow since k never exceeds n.
  assign ph0 = ph0_ovf ? PhW'(FullTurn) : PhW'(ph0_quo);
  assign ph1 = ph1_ovf ? PhW'(FullTurn) : PhW'(ph1_quo);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_valid_q <= 1'b0;
    end else begin
      dec_valid_q <= dly_valid_q[DivLat-1];
    end
  end

  always_ff @(posedge clk_i) begin
    dec_side_q <= dly_side_q[DivLat-1];
    dec_s0_q   <= decode_phase(ph0);
    dec_c0_q   <= decode_phase(ph0 + PhW'(Quarter));
    dec_s1_q   <= decode_phase(ph1);
    dec_c1_q   <= decode_phase(ph1 + PhW'(Quarter));
    dec_u_q    <= u_ovf ? 16'hFFFF : u_quo;
    dec_v_q    <= v_ovf ? 16'hFFFF : v_quo;
  end

  // --------------------------------------------------------------------------
  // Table reads.
  // --------------------------------------------------------------------------
  logic           rom_valid_q;
  tmg_pkg::side_t rom_side_q;
  logic [16:0]    rom_c0_q, rom_s0_q, rom_c1_q, rom_s1_q;
  logic           rom_c0_neg_q, rom_s0_neg_q, rom_c1_neg_q, rom_s1_neg_q;
  logic [15:0]    rom_u_q, rom_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_valid_q <= 1'b0;
    end else begin
      rom_valid_q <= dec_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rom_side_q   <= dec_side_q;
    rom_c0_q     <= RingRom[dec_c0_q[AddrW-1:0]];
    rom_s0_q     <= RingRom[dec_s0_q[AddrW-1:0]];
    rom_c1_q     <= TubeRom[dec_c1_q[AddrW-1:0]];
    rom_s1_q     <= TubeRom[dec_s1_q[AddrW-1:0]];
    rom_c0_neg_q <= dec_c0_q[AddrW];
    rom_s0_neg_q <= dec_s0_q[AddrW];
    rom_c1_neg_q <= dec_c1_q[AddrW];
    rom_s1_neg_q <= dec_s1_q[AddrW];
    rom_u_q      <= dec_u_q;
    rom_v_q      <= dec_v_q;
  end

  // --------------------------------------------------------------------------
  // Signed sine and cosine.
  // --------------------------------------------------------------------------
  logic               sgn_valid_q;
  tmg_pkg::side_t     sgn_side_q;
  logic signed [17:0] sgn_c0_q, sgn_s0_q, sgn_c1_q, sgn_s1_q;
  logic [15:0]        sgn_u_q, sgn_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sgn_valid_q <= 1'b0;
    end else begin
      sgn_valid_q <= rom_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sgn_side_q <= rom_side_q;
    sgn_c0_q   <= rom_c0_neg_q ? -$signed({1'b0, rom_c0_q}) : $signed({1'b0, rom_c0_q});
    sgn_s0_q   <= rom_s0_neg_q ? -$signed({1'b0, rom_s0_q}) : $signed({1'b0, rom_s0_q});
    sgn_c1_q   <= rom_c1_neg_q ? -$signed({1'b0, rom_c1_q}) : $signed({1'b0, rom_c1_q});
    sgn_s1_q   <= rom_s1_neg_q ? -$signed({1'b0, rom_s1_q}) : $signed({1'b0, rom_s1_q});
    sgn_u_q    <= rom_u_q;
    sgn_v_q    <= rom_v_q;
  end

  // --------------------------------------------------------------------------
  // First products. Rounding adds one half and floors, so ties go up.
  // --------------------------------------------------------------------------
  logic               mul1_valid_q;
  tmg_pkg::side_t     mul1_side_q;
  logic signed [17:0] mul1_rc_q, mul1_x0_q, mul1_z0_q;
  logic signed [16:0] mul1_y1_q;
  logic signed [17:0] mul1_c0_q, mul1_s0_q;
  logic [15:0]        mul1_u_q, mul1_v_q;
  logic signed [34:0] p_rc, p_y1, p_x0, p_z0;

  always_comb begin
    p_rc = $signed({1'b0, tube_radius_q}) * sgn_c1_q + 35'sd32768;
    p_y1 = $signed({1'b0, tube_radius_q}) * sgn_s1_q + 35'sd32768;
    p_x0 = $signed({1'b0, ring_radius_q}) * sgn_c0_q + 35'sd32768;
    p_z0 = $signed({1'b0, ring_radius_q}) * sgn_s0_q + 35'sd32768;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul1_valid_q <= 1'b0;
    end else begin
      mul1_valid_q <= sgn_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mul1_side_q <= sgn_side_q;
    mul1_rc_q   <= p_rc[33:16];
    mul1_y1_q   <= p_y1[32:16];
    mul1_x0_q   <= p_x0[33:16];
    mul1_z0_q   <= p_z0[33:16];
    mul1_c0_q   <= sgn_c0_q;
    mul1_s0_q   <= sgn_s0_q;
    mul1_u_q    <= sgn_u_q;
    mul1_v_q    <= sgn_v_q;
  end

  // --------------------------------------------------------------------------
  // Second products: the tube offset turned around the ring.
  // --------------------------------------------------------------------------
  logic               mul2_valid_q;
  tmg_pkg::side_t     mul2_side_q;
  logic signed [16:0] mul2_x1_q, mul2_z1_q, mul2_y1_q;
  logic signed [17:0] mul2_x0_q, mul2_z0_q;
  logic [15:0]        mul2_u_q, mul2_v_q;
  logic signed [35:0] p_x1, p_z1;

  always_comb begin
    p_x1 = mul1_rc_q * mul1_c0_q + 36'sd32768;
    p_z1 = mul1_rc_q * mul1_s0_q + 36'sd32768;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul2_valid_q <= 1'b0;
    end else begin
      mul2_valid_q <= mul1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mul2_side_q <= mul1_side_q;
    mul2_x1_q   <= p_x1[32:16];
    mul2_z1_q   <= p_z1[32:16];
    mul2_y1_q   <= mul1_y1_q;
    mul2_x0_q   <= mul1_x0_q;
    mul2_z0_q   <= mul1_z0_q;
    mul2_u_q    <= mul1_u_q;
    mul2_v_q    <= mul1_v_q;
  end

  // --------------------------------------------------------------------------
  // Result register. Cell results carry zeros in the vertex fields.
  // --------------------------------------------------------------------------
  logic               done_q;
  logic signed [17:0] pos_x_q, pos_y_q, pos_z_q, pos_x_d, pos_y_d, pos_z_d;
  logic signed [16:0] norm_x_q, norm_y_q, norm_z_q, norm_x_d, norm_y_d, norm_z_d;
  logic [15:0]        tex_u_q, tex_v_q, tex_u_d, tex_v_d;
  logic [15:0]        corner_a_q, corner_b_q, corner_c_q;
  logic               last_q;

  always_comb begin
    pos_x_d  = '0;
    pos_y_d  = '0;
    pos_z_d  = '0;
    norm_x_d = '0;
    norm_y_d = '0;
    norm_z_d = '0;
    tex_u_d  = '0;
    tex_v_d  = '0;
    if (!mul2_side_q.is_cell) begin
      pos_x_d  = mul2_x0_q + {mul2_x1_q[16], mul2_x1_q};
      pos_y_d  = {mul2_y1_q[16], mul2_y1_q};
      pos_z_d  = mul2_z0_q + {mul2_z1_q[16], mul2_z1_q};
      norm_x_d = mul2_x1_q;
      norm_y_d = mul2_y1_q;
      norm_z_d = mul2_z1_q;
      tex_u_d  = mul2_u_q;
      tex_v_d  = mul2_v_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= mul2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_x_q    <= pos_x_d;
    pos_y_q    <= pos_y_d;
    pos_z_q    <= pos_z_d;
    norm_x_q   <= norm_x_d;
    norm_y_q   <= norm_y_d;
    norm_z_q   <= norm_z_d;
    tex_u_q    <= tex_u_d;
    tex_v_q    <= tex_v_d;
    corner_a_q <= mul2_side_q.corner_a;
    corner_b_q <= mul2_side_q.corner_b;
    corner_c_q <= mul2_side_q.corner_c;
    last_q     <= mul2_side_q.last;
  end

  assign done_o     = done_q;
  assign pos_x_o    = pos_x_q;
  assign pos_y_o    = pos_y_q;
  assign pos_z_o    = pos_z_q;
  assign norm_x_o   = norm_x_q;
  assign norm_y_o   = norm_y_q;
  assign norm_z_o   = norm_z_q;
  assign tex_u_o    = tex_u_q;
  assign tex_v_o    = tex_v_q;
  assign corner_a_o = corner_a_q;
  assign corner_b_o = corner_b_q;
  assign corner_c_o = corner_c_q;
  assign last_o     = last_q;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
`include "assert_macros.svh"

  `ASSERT_PROP(a_cell_sets_busy, clk_i, rst_ni, (start && !busy && opcode_i == tmg_pkg::OpCell) |=> busy, "cell item did not block the next cycle")
  `ASSERT_PROP(a_busy_one_cycle, clk_i, rst_ni, busy |=> !busy, "busy held longer than one cycle")
  `ASSERT_PROP(a_first_tri_pairs, clk_i, rst_ni, (done_o && !last_o) |=> (done_o && last_o), "first triangle not followed by the second")
  `ASSERT_NEVER(a_cell_no_vertex, clk_i, rst_ni, done_o && (corner_a_o != 16'd0 || corner_b_o != 16'd0) && (tex_u_o != 16'd0 || tex_v_o != 16'd0), "result mixes cell and vertex fields")

endmodule

/* tb/sv/torus_mesh_generator_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// torus_mesh_generator_tb
// Self-checking bench for the torus tessellator. A clocked driver feeds items
// from a queue, an in-bench model predicts every vertex and triangle result,
// and a clocked monitor compares each strobed result with the oldest
// prediction. Register settings change between phases while the block is idle.
// ----------------------------------------------------------------------------
module torus_mesh_generator_tb;

  localparam int unsigned TableDepth = 1024;
  localparam int unsigned Quarter    = TableDepth / 4;
  localparam int unsigned ImageW     = 512;
  localparam int unsigned ImageH     = 512;
  localparam int unsigned DrainWait  = 40;
  localparam int unsigned StallLimit = 2000;
  // An index past the last register; writes to it must change nothing.
  localparam logic [3:0]  CfgUnused  = 4'd11;

  typedef struct {
    tmg_pkg::opcode_e op;
    logic [7:0]       ring;
    logic [7:0]       tube;
  } grid_item_t;

  typedef struct {
    logic signed [17:0] px, py, pz;
    logic signed [16:0] nx, ny, nz;
    logic [15:0]        u, v, a, b, c;
    logic               last;
  } mesh_result_t;

  logic clk_i, rst_ni;
  logic start, busy;
  logic opcode_i;
  logic [7:0] ring_step_i, tube_step_i;
  logic cfg_valid_i, cfg_ready_o;
  logic [3:0] cfg_index_i;
  logic [15:0] cfg_data_i;
  logic done_o, last_o;
  logic signed [17:0] pos_x_o, pos_y_o, pos_z_o;
  logic signed [16:0] norm_x_o, norm_y_o, norm_z_o;
  logic [15:0] tex_u_o, tex_v_o, corner_a_o, corner_b_o, corner_c_o;

  torus_mesh_generator DUT (
    .clk_i, .rst_ni, .start, .busy, .opcode_i, .ring_step_i, .tube_step_i,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .done_o, .pos_x_o, .pos_y_o, .pos_z_o, .norm_x_o, .norm_y_o, .norm_z_o,
    .tex_u_o, .tex_v_o, .corner_a_o, .corner_b_o, .corner_c_o, .last_o
  );

  // Model copy of the registers.
  logic [15:0] m_ring_r, m_tube_r;
  logic [7:0]  m_ring_n, m_tube_n;
  logic [11:0] m_left, m_top, m_width, m_height;

  longint quarter_wave [Quarter+1];
  grid_item_t   pending_items[$];
  mesh_result_t expected_results[$];
  int unsigned  mismatches;
  int unsigned  sender_idle_pct;
  int unsigned  stall_cycles;

  // Quarter-wave sine in Q1.16 from a truncated Taylor series in Q2.30.
  function automatic longint quarter_sine(int unsigned r);
    longint unsigned x, term;
    longint sum;
    x = longint'(r) * 64'd1686629713 / Quarter;
    term = x;
    sum = longint'(x);
    for (int n = 1; n <= 7; n++) begin
      term = (term * x) >> 30;
      term = ((term * x) >> 30) / ((2 * n) * (2 * n + 1));
      if (n % 2 == 1) sum -= longint'(term);
      else sum += longint'(term);
    end
    if (sum < 0) sum = 0;
    sum = (sum + 8192) / 16384;
    return (sum > 65536) ? 65536 : sum;
  endfunction

  function automatic longint phase_sine(int unsigned p);
    int unsigned q, r;
    q = (p / Quarter) % 4;
    r = p % Quarter;
    case (q)
      0: return quarter_wave[r];
      1: return quarter_wave[Quarter - r];
      2: return -quarter_wave[r];
      default: return -quarter_wave[Quarter - r];
    endcase
  endfunction

  // Product with a Q1.16 factor, rounded to nearest with ties upward.
  function automatic longint round_q16(longint a, longint b);
    longint t;
    t = a * b + 32768;
    if (t >= 0) return t / 65536;
    return -((-t + 65535) / 65536);
  endfunction

  function automatic logic [15:0] tex_coord(longint base, longint span, longint k,
                                             longint n, longint img);
    longint den, num, t;
    den = n * img;
    num = (base * n + span * k) * 65536;
    t = (num + den / 2) / den;
    return (t > 65535) ? 16'hFFFF : t[15:0];
  endfunction

  // Works out the results of one accepted item and queues them.
  function automatic void predict_mesh(grid_item_t it);
    mesh_result_t r;
    int unsigned n0, n1, i, j, stride, v00;
    longint c0, s0, c1, s1, rc, x1, y1, z1, x0, z0;
    n0 = (m_ring_n == 0) ? 1 : m_ring_n;
    n1 = (m_tube_n == 0) ? 1 : m_tube_n;
    i = it.ring;
    j = it.tube;
    r = '{default: '0};
    if (it.op == tmg_pkg::OpVertex) begin
      if (i > n0) i = n0;
      if (j > n1) j = n1;
      c0 = phase_sine(i * 4 * Quarter / n0 + Quarter);
      s0 = phase_sine(i * 4 * Quarter / n0);
      c1 = phase_sine(j * 4 * Quarter / n1 + Quarter);
      s1 = phase_sine(j * 4 * Quarter / n1);
      rc = round_q16(longint'(m_tube_r), c1);
      x1 = round_q16(rc, c0);
      y1 = round_q16(longint'(m_tube_r), s1);
      z1 = round_q16(rc, s0);
      x0 = round_q16(longint'(m_ring_r), c0);
      z0 = round_q16(longint'(m_ring_r), s0);
      r.px = 18'(x0 + x1);
      r.py = 18'(y1);
      r.pz = 18'(z0 + z1);
      r.nx = 17'(x1);
      r.ny = 17'(y1);
      r.nz = 17'(z1);
      r.u = tex_coord(m_left, m_width, i, n0, ImageW);
      r.v = tex_coord(m_top, m_height, j, n1, ImageH);
      r.last = 1'b1;
      expected_results.push_back(r);
    end else begin
      // Cells clamp one step short of the vertex grid edge.
      if (i > n0 - 1) i = n0 - 1;
      if (j > n1 - 1) j = n1 - 1;
      stride = n1 + 1;
      v00 = i * stride + j;
      r.a = 16'(v00);
      r.b = 16'(v00 + 1);
      r.c = 16'(v00 + stride);
      r.last = 1'b0;
      expected_results.push_back(r);
      r.a = 16'(v00 + stride);
      r.b = 16'(v00 + 1);
      r.c = 16'(v00 + stride + 1);
      r.last = 1'b1;
      expected_results.push_back(r);
    end
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Driver: an item is taken at an edge with start high and busy low. The next
  // item (or an idle cycle) is chosen in the same step.
  always @(posedge clk_i or negedge rst_ni) begin
    grid_item_t nxt;
    if (!rst_ni) begin
      start       <= 1'b0;
      opcode_i    <= 1'b0;
      ring_step_i <= '0;
      tube_step_i <= '0;
    end else begin
      if (start && !busy) begin
        predict_mesh(pending_items.pop_front());
      end
      // While busy holds the current item, it must stay on the ports.
      if (!(start && busy)) begin
        if (pending_items.size() > 0 &&
            $urandom_range(0, 99) >= sender_idle_pct) begin
          nxt = pending_items[0];
          start       <= 1'b1;
          opcode_i    <= nxt.op;
          ring_step_i <= nxt.ring;
          tube_step_i <= nxt.tube;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: each strobe is checked against the oldest prediction.
  always @(posedge clk_i) begin
    mesh_result_t e;
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result, nothing predicted");
      end else begin
        e = expected_results.pop_front();
        if (pos_x_o !== e.px || pos_y_o !== e.py || pos_z_o !== e.pz ||
            norm_x_o !== e.nx || norm_y_o !== e.ny || norm_z_o !== e.nz ||
            tex_u_o !== e.u || tex_v_o !== e.v || corner_a_o !== e.a ||
            corner_b_o !== e.b || corner_c_o !== e.c || last_o !== e.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch exp pos %0d %0d %0d norm %0d %0d %0d tex %0d %0d",
                     e.px, e.py, e.pz, e.nx, e.ny, e.nz, e.u, e.v);
            $display("         got pos %0d %0d %0d norm %0d %0d %0d tex %0d %0d",
                     pos_x_o, pos_y_o, pos_z_o, norm_x_o, norm_y_o, norm_z_o,
                     tex_u_o, tex_v_o);
            $display("  exp corners %0d %0d %0d last %0b, got %0d %0d %0d last %0b",
                     e.a, e.b, e.c, e.last, corner_a_o, corner_b_o, corner_c_o,
                     last_o);
          end
        end
      end
    end
  end

  // Watchdog: the run dies if nothing moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("torus_mesh_generator regression: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // One register write; the model copy follows at the accepting edge.
  // Valid is left high so back-to-back writes never glitch it.
  task automatic write_reg(logic [3:0] idx, logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      tmg_pkg::CfgRingRadius: m_ring_r = data;
      tmg_pkg::CfgTubeRadius: m_tube_r = data;
      tmg_pkg::CfgRingSegs:   m_ring_n = data[7:0];
      tmg_pkg::CfgTubeSegs:   m_tube_n = data[7:0];
      tmg_pkg::CfgTexLeft:    m_left   = data[11:0];
      tmg_pkg::CfgTexTop:     m_top    = data[11:0];
      tmg_pkg::CfgTexWidth:   m_width  = data[11:0];
      tmg_pkg::CfgTexHeight:  m_height = data[11:0];
      default: ;
    endcase
  endtask

  task automatic load_regs(logic [15:0] rr, logic [15:0] tr, logic [15:0] rn,
                           logic [15:0] tn, logic [15:0] l, logic [15:0] t,
                           logic [15:0] w, logic [15:0] h);
    write_reg(tmg_pkg::CfgRingRadius, rr);
    write_reg(tmg_pkg::CfgTubeRadius, tr);
    write_reg(tmg_pkg::CfgRingSegs, rn);
    write_reg(tmg_pkg::CfgTubeSegs, tn);
    write_reg(tmg_pkg::CfgTexLeft, l);
    write_reg(tmg_pkg::CfgTexTop, t);
    write_reg(tmg_pkg::CfgTexWidth, w);
    write_reg(tmg_pkg::CfgTexHeight, h);
    write_reg(CfgUnused, 16'(($urandom())));
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Waits until every item is taken and every result seen, then lets the
  // pipeline drain before registers may change.
  task automatic wait_drained();
    while (pending_items.size() > 0 || expected_results.size() > 0 || start)
      @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  function automatic void add_item(tmg_pkg::opcode_e op, logic [7:0] i, logic [7:0] j);
    grid_item_t it;
    it.op = op;
    it.ring = i;
    it.tube = j;
    pending_items.push_back(it);
  endfunction

  // Random item: mostly inside the grid, sometimes anywhere in the field.
  function automatic void add_random_item();
    logic [7:0] i, j;
    i = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                     : 8'($urandom_range(0, m_ring_n + 1));
    j = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                     : 8'($urandom_range(0, m_tube_n + 1));
    add_item($urandom_range(0, 1) ? tmg_pkg::OpCell : tmg_pkg::OpVertex, i, j);
  endfunction

  initial begin
    logic [15:0] rn, tn;
    mismatches = 0;
    sender_idle_pct = 20;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    for (int r = 0; r <= Quarter; r++) quarter_wave[r] = quarter_sine(r);
    m_ring_r = 16'd256;
    m_tube_r = 16'd128;
    m_ring_n = 8'd8;
    m_tube_n = 8'd8;
    m_left = '0;
    m_top = '0;
    m_width = '0;
    m_height = '0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part on the reset settings: corners, clamping, both operations.
    add_item(tmg_pkg::OpVertex, 8'd0, 8'd0);
    add_item(tmg_pkg::OpVertex, 8'd8, 8'd8);
    add_item(tmg_pkg::OpVertex, 8'd2, 8'd6);
    add_item(tmg_pkg::OpVertex, 8'd255, 8'd255);
    add_item(tmg_pkg::OpVertex, 8'd9, 8'd170);
    add_item(tmg_pkg::OpCell, 8'd0, 8'd0);
    add_item(tmg_pkg::OpCell, 8'd7, 8'd7);
    add_item(tmg_pkg::OpCell, 8'd8, 8'd8);
    add_item(tmg_pkg::OpCell, 8'd255, 8'd85);
    wait_drained();

    // Extremes: zero segment counts act as one, full radii and texture.
    load_regs(16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_item(tmg_pkg::OpVertex, 8'd0, 8'd0);
    add_item(tmg_pkg::OpVertex, 8'd1, 8'd1);
    add_item(tmg_pkg::OpVertex, 8'd255, 8'd255);
    add_item(tmg_pkg::OpCell, 8'd0, 8'd0);
    add_item(tmg_pkg::OpCell, 8'd255, 8'd255);
    wait_drained();

    // Other extreme: largest grids, zero radii, a 1 x 4095 texture window.
    load_regs(16'd0, 16'd0, 16'd255, 16'd255, 16'd0, 16'd0, 16'd1, 16'd4095);
    add_item(tmg_pkg::OpVertex, 8'd255, 8'd0);
    add_item(tmg_pkg::OpVertex, 8'd64, 8'd191);
    add_item(tmg_pkg::OpVertex, 8'd127, 8'd128);
    add_item(tmg_pkg::OpCell, 8'd254, 8'd254);
    add_item(tmg_pkg::OpCell, 8'd255, 8'd255);
    add_item(tmg_pkg::OpCell, 8'd0, 8'd255);
    wait_drained();

    // Random phases: sender idles 20%, then 57%, then never.
    for (int ph = 0; ph < 6; ph++) begin
      sender_idle_pct = (ph < 2) ? 20 : (ph < 4) ? 57 : 0;
      rn = ($urandom_range(0, 4) == 0) ? 16'(255 - $urandom_range(0, 3))
                                       : 16'($urandom_range(0, 24));
      tn = ($urandom_range(0, 4) == 0) ? 16'(255 - $urandom_range(0, 3))
                                       : 16'($urandom_range(0, 24));
      load_regs(16'($urandom()), 16'($urandom()), rn | 16'($urandom() & 16'hFF00),
                tn | 16'($urandom() & 16'hFF00), 16'($urandom()), 16'($urandom()),
                16'($urandom()), 16'($urandom()));
      for (int k = 0; k < 110; k++) add_random_item();
      wait_drained();
    end

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("torus_mesh_generator regression: pass");
    end else begin
      $display("torus_mesh_generator regression: fail");
    end
    $finish;
  end

endmodule
